// ===== hw/rtl/ppc_pkg.sv =====
// package for the polar pose controller: payload types, constants and tables
package ppc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS = 16;
  localparam int POS_W = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SQ_STEPS = 18;
  localparam int NIT = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;
  localparam int LATENCY = NIT + 8;
  localparam logic [18:0] PI_Q16 = 19'd205887;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_TARGET_X = 3'd0;
  localparam logic [2:0] REG_TARGET_Y = 3'd1;
  localparam logic [2:0] REG_TARGET_HEADING = 3'd2;
  localparam logic [2:0] REG_GOAL_ENABLE = 3'd3;
  localparam logic [2:0] REG_GAIN_DISTANCE = 3'd4;
  localparam logic [2:0] REG_GAIN_BEARING = 3'd5;
  localparam logic [2:0] REG_GAIN_FINAL_ANGLE = 3'd6;
  localparam logic [2:0] REG_NEAR_THRESHOLD = 3'd7;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic near_goal;
    logic enabled;
  } result_t;

  function automatic logic [31:0] atan_tab(input int i);
    case (i)
      0: atan_tab = 32'h20000000;
      1: atan_tab = 32'h12E4051E;
      2: atan_tab = 32'h09FB385B;
      3: atan_tab = 32'h051111D4;
      4: atan_tab = 32'h028B0D43;
      5: atan_tab = 32'h0145D7E1;
      6: atan_tab = 32'h00A2F61E;
      7: atan_tab = 32'h00517C55;
      8: atan_tab = 32'h0028BE53;
      9: atan_tab = 32'h00145F2F;
      10: atan_tab = 32'h000A2F98;
      11: atan_tab = 32'h000517CC;
      12: atan_tab = 32'h00028BE6;
      13: atan_tab = 32'h000145F3;
      14: atan_tab = 32'h0000A2FA;
      15: atan_tab = 32'h0000517D;
      16: atan_tab = 32'h000028BE;
      17: atan_tab = 32'h0000145F;
      18: atan_tab = 32'h00000A30;
      19: atan_tab = 32'h00000518;
      20: atan_tab = 32'h0000028C;
      21: atan_tab = 32'h00000146;
      22: atan_tab = 32'h000000A3;
      23: atan_tab = 32'h00000051;
      default: atan_tab = 32'h0;
    endcase
  endfunction

  function automatic logic signed [15:0] fold_quarter(input logic signed [15:0] a);
    if (a > 16'sd16384 || a < -16'sd16384) begin
      fold_quarter = {~a[15], a[14:0]};
    end else begin
      fold_quarter = a;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
    if (v > 56'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -56'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// ===== hw/rtl/polar_pose_controller_unit.sv =====
// polar pose controller top level: register port, cordic bearing and sqrt distance pipeline
// start to done pipeline: 16 cordic and 18 sqrt steps
// throughput: one pose per cycle, busy stays low; the pipeline length is set by
// the longer of the cordic rotation chain and the bit-per-stage square root
// results are strobed on done for one cycle; the receiver cannot stall
// reset: synchronous rst clears valid bits and loads register defaults
module polar_pose_controller_unit import ppc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  pose_t pose,
  output logic done,
  output result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic signed [15:0] target_x, target_y, target_heading;
  logic goal_enable;
  logic signed [15:0] gain_distance, gain_bearing, gain_final_angle;
  logic [11:0] near_threshold;
  logic [2:0] reg_idx;
  logic accept;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign accept = start && !busy;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      target_heading <= '0;
      goal_enable <= 1'b0;
      gain_distance <= 16'sd768;
      gain_bearing <= 16'sd2048;
      gain_final_angle <= -16'sd384;
      near_threshold <= 12'd26;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_TARGET_X: target_x <= pwdata[15:0];
        REG_TARGET_Y: target_y <= pwdata[15:0];
        REG_TARGET_HEADING: target_heading <= pwdata[15:0];
        REG_GOAL_ENABLE: goal_enable <= pwdata[0];
        REG_GAIN_DISTANCE: gain_distance <= pwdata[15:0];
        REG_GAIN_BEARING: gain_bearing <= pwdata[15:0];
        REG_GAIN_FINAL_ANGLE: gain_final_angle <= pwdata[15:0];
        REG_NEAR_THRESHOLD: near_threshold <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET_X: prdata = {16'h0, target_x};
      REG_TARGET_Y: prdata = {16'h0, target_y};
      REG_TARGET_HEADING: prdata = {16'h0, target_heading};
      REG_GOAL_ENABLE: prdata = {31'h0, goal_enable};
      REG_GAIN_DISTANCE: prdata = {16'h0, gain_distance};
      REG_GAIN_BEARING: prdata = {16'h0, gain_bearing};
      REG_GAIN_FINAL_ANGLE: prdata = {16'h0, gain_final_angle};
      REG_NEAR_THRESHOLD: prdata = {20'h0, near_threshold};
      default: prdata = '0;
    endcase
  end

  // stage 1: vector to goal
  logic signed [POS_W-1:0] px_t, py_t, tx_t, ty_t;
  logic signed [16:0] px_e, py_e, tx_e, ty_e;
  logic v1;
  logic signed [16:0] dx1, dy1;
  logic signed [15:0] hd1;

  assign px_t = pose.pose_x[POS_W-1:0];
  assign py_t = pose.pose_y[POS_W-1:0];
  assign tx_t = target_x[POS_W-1:0];
  assign ty_t = target_y[POS_W-1:0];
  assign px_e = {{(17-POS_W){px_t[POS_W-1]}}, px_t};
  assign py_e = {{(17-POS_W){py_t[POS_W-1]}}, py_t};
  assign tx_e = {{(17-POS_W){tx_t[POS_W-1]}}, tx_t};
  assign ty_e = {{(17-POS_W){ty_t[POS_W-1]}}, ty_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    dx1 <= tx_e - px_e;
    dy1 <= ty_e - py_e;
    hd1 <= pose.pose_heading;
  end

  // stage 2: squares and cordic pre-rotation
  logic v2, zero2;
  logic [33:0] sqx2, sqy2;
  logic signed [31:0] cx2, cy2;
  logic [31:0] cz2;
  logic signed [15:0] hd2;
  logic signed [33:0] sqx_p, sqy_p;

  assign sqx_p = dx1 * dx1;
  assign sqy_p = dy1 * dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sqx2 <= sqx_p;
    sqy2 <= sqy_p;
    zero2 <= (dx1 == 17'sd0) && (dy1 == 17'sd0);
    hd2 <= hd1;
    if (dx1 < 17'sd0) begin
      cx2 <= -(32'(dx1) <<< 12);
      cy2 <= -(32'(dy1) <<< 12);
      cz2 <= 32'h80000000;
    end else begin
      cx2 <= 32'(dx1) <<< 12;
      cy2 <= 32'(dy1) <<< 12;
      cz2 <= '0;
    end
  end

  // stage 3: squared distance and near test; feeds the iteration stages
  logic ivld [NIT+1];
  logic izero [NIT+1];
  logic inear [NIT+1];
  logic signed [15:0] ihd [NIT+1];
  logic signed [31:0] icx [NIT+1];
  logic signed [31:0] icy [NIT+1];
  logic [31:0] icz [NIT+1];
  logic [35:0] irem [NIT+1];
  logic [35:0] irt [NIT+1];
  logic [23:0] thr_sq;

  assign thr_sq = near_threshold * near_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivld[0] <= 1'b0;
    end else begin
      ivld[0] <= v2;
    end
    irem[0] <= 36'(sqx2) + 36'(sqy2);
    inear[0] <= (36'(sqx2) + 36'(sqy2)) < 36'(thr_sq);
    irt[0] <= '0;
    izero[0] <= zero2;
    ihd[0] <= hd2;
    icx[0] <= cx2;
    icy[0] <= cy2;
    icz[0] <= cz2;
  end

  for (genvar k = 0; k < NIT; k++) begin : g_iter
    logic [35:0] bitv, trial;
    assign bitv = (k < SQ_STEPS) ? (36'd1 << (34 - 2 * k)) : 36'd0;
    assign trial = irt[k] + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        ivld[k+1] <= 1'b0;
      end else begin
        ivld[k+1] <= ivld[k];
      end
      izero[k+1] <= izero[k];
      inear[k+1] <= inear[k];
      ihd[k+1] <= ihd[k];
      if (k < SQ_STEPS) begin
        if (irem[k] >= trial) begin
          irem[k+1] <= irem[k] - trial;
          irt[k+1] <= (irt[k] >> 1) + bitv;
        end else begin
          irem[k+1] <= irem[k];
          irt[k+1] <= irt[k] >> 1;
        end
      end else begin
        irem[k+1] <= irem[k];
        irt[k+1] <= irt[k];
      end
      if (k < CORDIC_STEPS) begin
        if (icy[k] >= 32'sd0) begin
          icx[k+1] <= icx[k] + (icy[k] >>> k);
          icy[k+1] <= icy[k] - (icx[k] >>> k);
          icz[k+1] <= icz[k] + atan_tab(k);
        end else begin
          icx[k+1] <= icx[k] - (icy[k] >>> k);
          icy[k+1] <= icy[k] + (icx[k] >>> k);
          icz[k+1] <= icz[k] - atan_tab(k);
        end
      end else begin
        icx[k+1] <= icx[k];
        icy[k+1] <= icy[k];
        icz[k+1] <= icz[k];
      end
    end
  end

  // post stage 1: angle errors, direction, rounded distance
  logic [31:0] zr;
  logic signed [15:0] bear, a_raw, theta_c, b_raw;
  logic q1v, q1near, q1neg;
  logic signed [15:0] q1a, q1b, q1th;
  logic [17:0] q1d;

  assign zr = icz[NIT] + 32'h8000;
  assign bear = izero[NIT] ? 16'sd0 : zr[31:16];
  assign a_raw = bear - ihd[NIT];
  assign theta_c = ihd[NIT] - target_heading;
  assign b_raw = -theta_c - a_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1v <= 1'b0;
    end else begin
      q1v <= ivld[NIT];
    end
    q1near <= inear[NIT];
    q1neg <= !(a_raw >= -16'sd16384 && a_raw <= 16'sd16384);
    q1a <= fold_quarter(a_raw);
    q1b <= fold_quarter(b_raw);
    q1th <= theta_c;
    q1d <= (irem[NIT] > irt[NIT]) ? 18'(irt[NIT] + 36'd1) : irt[NIT][17:0];
  end

  // post stage 2: gain products
  logic q2v, q2near, q2neg;
  logic signed [31:0] q2pa, q2pb, q2pt;
  logic signed [34:0] q2pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2v <= 1'b0;
    end else begin
      q2v <= q1v;
    end
    q2near <= q1near;
    q2neg <= q1neg;
    q2pa <= gain_bearing * q1a;
    q2pb <= gain_final_angle * q1b;
    q2pt <= gain_final_angle * q1th;
    q2pv <= gain_distance * $signed({1'b0, q1d});
  end

  // post stage 3: gain sum and signed speed
  logic q3v, q3near;
  logic signed [32:0] q3g;
  logic signed [35:0] q3s;

  always_ff @(posedge clk) begin
    if (rst) begin
      q3v <= 1'b0;
    end else begin
      q3v <= q2v;
    end
    q3near <= q2near;
    q3g <= q2near ? 33'(q2pt) : (33'(q2pa) + 33'(q2pb));
    q3s <= q2neg ? -36'(q2pv) : 36'(q2pv);
  end

  // post stage 4: radian scaling
  logic q4v, q4near;
  logic signed [52:0] q4w;
  logic signed [35:0] q4s;

  always_ff @(posedge clk) begin
    if (rst) begin
      q4v <= 1'b0;
    end else begin
      q4v <= q3v;
    end
    q4near <= q3near;
    q4w <= q3g * $signed({1'b0, PI_Q16});
    q4s <= q3s;
  end

  // output register: rounding, saturation, enable gate
  logic signed [55:0] w_rnd, v_rnd;

  assign w_rnd = (56'(q4w) + (56'sd1 <<< 28)) >>> 29;
  assign v_rnd = (56'(q4s) + 56'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q4v;
    end
    if (goal_enable) begin
      result.linear_speed <= q4near ? 16'sd0 : sat16(v_rnd);
      result.turn_rate <= sat16(w_rnd);
      result.near_goal <= q4near;
      result.enabled <= 1'b1;
    end else begin
      result <= '0;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LATENCY) done) else $error("result transfer missing");
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    done && !result.enabled |-> result.linear_speed == 16'sd0 &&
    result.turn_rate == 16'sd0 && !result.near_goal) else $error("disabled result not zero");
  a_near: assert property (@(posedge clk) disable iff (rst)
    done && result.near_goal |-> result.linear_speed == 16'sd0)
    else $error("speed nonzero near goal");

endmodule
